// ===== rtl/dird_pkg.sv =====
package dird_pkg;

    // Field widths fixed by the stream payload
    localparam int ACTION_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    localparam int S_TDATA_W = 40;  // action + value, padded to bytes
    localparam int M_TDATA_W = 72;  // status, top, bottom, count, empty

    // Parameter defaults
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Action codes; unused codes behave as peek
    localparam logic [ACTION_W-1:0] ACT_PUSH       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_TOP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_BOTTOM = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted input transaction
        logic execute;   // apply the operation to the store
        logic present;   // load the result register
    } dird_cmd_t;

endpackage

// ===== rtl/dird_ctrl.sv =====
module dird_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dird_pkg::dird_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOOK = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = S_LOOK;
            end
            S_LOOK: begin
                // wait here while the previous result is still held
                if (out_free) begin
                    cmd.present    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/dird_datapath.sv =====
module dird_datapath #(
    parameter int DEPTH      = dird_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dird_pkg::DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dird_pkg::dird_cmd_t             cmd,
    input  logic [dird_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic [dird_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    // Latched transaction
    logic [dird_pkg::ACTION_W-1:0] act_reg;
    logic [DATA_WIDTH-1:0]         word_reg;
    logic [63:0]                   val_ext;

    // Row of cells, position 0 is the bottom
    logic [DATA_WIDTH-1:0] cells_reg  [DEPTH];
    logic [DATA_WIDTH-1:0] cells_next [DEPTH];
    logic [CW-1:0]         count_reg, count_next;
    logic [dird_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [DEPTH-1:0] match;
    logic [IW-1:0]    pos;
    logic             found, empty, full;

    // Result register
    logic [dird_pkg::STATUS_W-1:0]    res_status_reg;
    logic [dird_pkg::VALUE_W-1:0]     res_top_reg, res_bottom_reg;
    logic [dird_pkg::COUNT_OUT_W-1:0] res_count_reg;
    logic                             res_empty_reg;

    logic [DATA_WIDTH-1:0] top_word;
    logic [63:0]           top_ext, bottom_ext;
    logic [15:0]           count_ext;

    assign val_ext = {32'b0, s_tdata[34:3]};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= s_tdata[2:0];
            word_reg <= DATA_WIDTH'(val_ext);
        end
    end

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

    // Parallel compare against every occupied cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CW'(i) < count_reg) && (cells_reg[i] == word_reg);
        end
    end
    assign found = |match;

    // Values are distinct, so at most one match: OR-encode its index
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (match[i]) begin
                pos = pos | IW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cells_next[i] = cells_reg[i];
        end
        count_next  = count_reg;
        status_next = dird_pkg::ST_DONE;
        unique case (act_reg)
            dird_pkg::ACT_PUSH: begin
                if (found) begin
                    status_next = dird_pkg::ST_DUP;
                end else if (full) begin
                    status_next = dird_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CW'(i) == count_reg) begin
                            cells_next[i] = word_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            dird_pkg::ACT_POP_TOP: begin
                if (empty) begin
                    status_next = dird_pkg::ST_NONE;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            dird_pkg::ACT_POP_BOTTOM: begin
                if (empty) begin
                    status_next = dird_pkg::ST_NONE;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        cells_next[i] = cells_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            dird_pkg::ACT_REMOVE: begin
                if (!found) begin
                    status_next = dird_pkg::ST_NONE;
                end else begin
                    // close the gap: everything from the hit upward moves down
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (IW'(i) >= pos) begin
                            cells_next[i] = cells_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                // peek and unused codes
                if (empty) begin
                    status_next = dird_pkg::ST_NONE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            for (int i = 0; i < DEPTH; i++) begin
                cells_reg[i] <= cells_next[i];
            end
            status_reg <= status_next;
        end
    end

    // Top is the cell just below the count
    always_comb begin
        top_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i + 1) == count_reg) begin
                top_word = top_word | cells_reg[i];
            end
        end
    end

    assign top_ext    = 64'(top_word);
    assign bottom_ext = empty ? 64'd0 : 64'(cells_reg[0]);
    assign count_ext  = 16'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.present) begin
            res_status_reg <= status_reg;
            res_top_reg    <= top_ext[31:0];
            res_bottom_reg <= bottom_ext[31:0];
            res_count_reg  <= count_ext[4:0];
            res_empty_reg  <= empty;
        end
    end

    assign m_tdata = {res_empty_reg, res_count_reg, res_bottom_reg,
                      res_top_reg, res_status_reg};

endmodule

// ===== rtl/dedup_input_restricted_deque_core.sv =====
// Deque of distinct words, pushed only at the top.
// Input stream (s_*): one transaction per operation, action 0 push top,
// 1 pop top, 2 pop bottom, 3 remove value, 4 (and 5..7) peek.
// Output stream (m_*): one transaction per operation with the status and a
// snapshot of the store afterward: top, bottom, count, empty flag.
// Each operation is captured, then executed on the store, then loaded into
// the output register once that register is free; the controller's
// capture / execute / present sequence keeps one operation in flight, and the
// compare and shift over the whole cell row happen in the execute step.
// The next operation is accepted while a result still waits in the output
// register; if the receiver keeps stalling, the block holds the finished
// result internally and drops s_tready until the output register frees.
// Reset (aresetn low, synchronous) empties the store, clears the output
// valid flag and returns the controller to idle; cell contents are not
// cleared, they are masked by the count.
module dedup_input_restricted_deque_core #(
    parameter int DEPTH      = dird_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dird_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // [2:0] action, [34:3] value, [39:35] zero
    input  logic [dird_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] status, [33:2] top_value, [65:34] bottom_value,
    // [70:66] entry_count, [71] is_empty
    output logic [dird_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    dird_pkg::dird_cmd_t cmd;

    // Sequencer: owns both handshakes
    dird_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Cell row, compare/shift logic and result register
    dird_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

    // One operation in flight: no back-to-back accepts
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while one is in flight");

    // An empty snapshot reports zero top and bottom
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[71] |-> (m_tdata[33:2] == 32'd0) && (m_tdata[65:34] == 32'd0))
        else $error("empty result with nonzero top or bottom");

    // Empty flag agrees with the count while the count fits the field
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (DEPTH < 32) |-> (m_tdata[71] == (m_tdata[70:66] == 5'd0)))
        else $error("empty flag disagrees with entry count");

    // A full-push status only when the store is at capacity
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (DEPTH < 32) && (m_tdata[1:0] == dird_pkg::ST_FULL)
            |-> (m_tdata[70:66] == 5'(DEPTH)))
        else $error("full status with store below capacity");

endmodule

// ===== sim/dedup_input_restricted_deque_core_test.sv =====
`timescale 1ns / 100ps

module dedup_input_restricted_deque_core_test;

    localparam int DEPTH = dird_pkg::DEPTH_DEF;
    // codes 5..7 alias peek
    localparam logic [dird_pkg::ACTION_W-1:0] ACT_SPARE_A  = 3'd5;
    localparam logic [dird_pkg::ACTION_W-1:0] ACT_SPARE_B  = 3'd6;
    localparam logic [dird_pkg::ACTION_W-1:0] ACT_CODE_MAX = 3'd7;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_ITEMS  = 200;   // tail of the run with no idling
    localparam int POOL_SIZE    = 24;    // more than DEPTH so full is reachable

    // One result transaction, unpacked from m_tdata
    typedef struct packed {
        logic [dird_pkg::STATUS_W-1:0]    status;
        logic [dird_pkg::VALUE_W-1:0]     top_value;
        logic [dird_pkg::VALUE_W-1:0]     bottom_value;
        logic [dird_pkg::COUNT_OUT_W-1:0] entry_count;
        logic                             is_empty;
    } deque_result_t;

    // Directed row: reps > 1 repeats the action with value, value+1, ...
    typedef struct packed {
        logic [dird_pkg::ACTION_W-1:0] action;
        logic [dird_pkg::VALUE_W-1:0]  value;
        logic [4:0]                    reps;
        logic                          typed;   // 'want' holds a hand-written result
        deque_result_t                 want;
    } stim_row_t;

    // What one accepted transaction should produce
    typedef struct packed {
        deque_result_t model;
        logic          typed;
        deque_result_t want;
    } pending_t;

    localparam deque_result_t NO_WANT = '0;

    localparam stim_row_t DIR_ROWS [25] = '{
        // empty store: every action reports nothing found / empty
        '{dird_pkg::ACT_PEEK,       32'h0, 5'd1, 1'b1,
          '{dird_pkg::ST_NONE, 32'h0, 32'h0, 5'd0, 1'b1}},
        '{dird_pkg::ACT_POP_TOP,    32'h0, 5'd1, 1'b1,
          '{dird_pkg::ST_NONE, 32'h0, 32'h0, 5'd0, 1'b1}},
        '{dird_pkg::ACT_POP_BOTTOM, 32'h0, 5'd1, 1'b1,
          '{dird_pkg::ST_NONE, 32'h0, 32'h0, 5'd0, 1'b1}},
        '{dird_pkg::ACT_REMOVE,     32'h0, 5'd1, 1'b1,
          '{dird_pkg::ST_NONE, 32'h0, 32'h0, 5'd0, 1'b1}},
        '{ACT_SPARE_A,              32'h0, 5'd1, 1'b1,
          '{dird_pkg::ST_NONE, 32'h0, 32'h0, 5'd0, 1'b1}},
        '{ACT_CODE_MAX,             32'h0, 5'd1, 1'b1,
          '{dird_pkg::ST_NONE, 32'h0, 32'h0, 5'd0, 1'b1}},
        // value extremes, duplicate, unused codes on a non-empty store
        '{dird_pkg::ACT_PUSH,       32'h7fffffff, 5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h7fffffff, 32'h7fffffff, 5'd1, 1'b0}},
        '{dird_pkg::ACT_PUSH,       32'h80000000, 5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h80000000, 32'h7fffffff, 5'd2, 1'b0}},
        '{dird_pkg::ACT_PUSH,       32'h7fffffff, 5'd1,  1'b1,
          '{dird_pkg::ST_DUP,  32'h80000000, 32'h7fffffff, 5'd2, 1'b0}},
        '{dird_pkg::ACT_PEEK,       32'h0,        5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h80000000, 32'h7fffffff, 5'd2, 1'b0}},
        '{ACT_SPARE_B,              32'hffffffff, 5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h80000000, 32'h7fffffff, 5'd2, 1'b0}},
        '{dird_pkg::ACT_REMOVE,     32'h12345678, 5'd1,  1'b1,
          '{dird_pkg::ST_NONE, 32'h80000000, 32'h7fffffff, 5'd2, 1'b0}},
        '{dird_pkg::ACT_POP_BOTTOM, 32'h0,        5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h80000000, 32'h80000000, 5'd1, 1'b0}},
        // removing the last element empties top and bottom
        '{dird_pkg::ACT_REMOVE,     32'h80000000, 5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h0, 32'h0, 5'd0, 1'b1}},
        '{dird_pkg::ACT_PUSH,       32'h0,        5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h0, 32'h0, 5'd1, 1'b0}},
        '{dird_pkg::ACT_PUSH,       32'hffffffff, 5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'hffffffff, 32'h0, 5'd2, 1'b0}},
        // pop top must expose the previous entry as the new top
        '{dird_pkg::ACT_POP_TOP,    32'h0,        5'd1,  1'b1,
          '{dird_pkg::ST_DONE, 32'h0, 32'h0, 5'd1, 1'b0}},
        // fill to DEPTH with 1..15, then push into full: dropped, and dup wins
        '{dird_pkg::ACT_PUSH,       32'h1,        5'd15, 1'b0, NO_WANT},
        '{dird_pkg::ACT_PUSH,       32'h55555555, 5'd1,  1'b1,
          '{dird_pkg::ST_FULL, 32'hf, 32'h0, 5'd16, 1'b0}},
        '{dird_pkg::ACT_PUSH,       32'h7,        5'd1,  1'b1,
          '{dird_pkg::ST_DUP,  32'hf, 32'h0, 5'd16, 1'b0}},
        '{dird_pkg::ACT_REMOVE,     32'h8,        5'd1,  1'b0, NO_WANT},
        '{dird_pkg::ACT_PUSH,       32'haaaaaaaa, 5'd1,  1'b0, NO_WANT},
        '{dird_pkg::ACT_POP_TOP,    32'h0,        5'd1,  1'b0, NO_WANT},
        // drain from the bottom, one pop past empty
        '{dird_pkg::ACT_POP_BOTTOM, 32'h0,        5'd16, 1'b0, NO_WANT},
        '{dird_pkg::ACT_PEEK,       32'h0,        5'd1,  1'b1,
          '{dird_pkg::ST_NONE, 32'h0, 32'h0, 5'd0, 1'b1}}
    };

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic [dird_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [dird_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    // Shadow copy of the store: index 0 is the bottom, last index the top
    logic [dird_pkg::VALUE_W-1:0] shadow_store [$];
    pending_t                     pending_results [$];
    logic [dird_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
    int                           fail_cnt = 0;
    bit                           quiet_in = 1'b0;   // sender never idles
    bit                           quiet_out = 1'b0;  // receiver never stalls
    int                           stall_left = 0;

    dedup_input_restricted_deque_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Generous cap; a correct run finishes far earlier
    initial begin
        #2_000_000;
        $display("** dedup_input_restricted_deque_core: FAILED **");
        $finish;
    end

    // Position of v in the shadow store, -1 if absent
    function automatic int find_entry(logic [dird_pkg::VALUE_W-1:0] v);
        for (int i = 0; i < shadow_store.size(); i++)
            if (shadow_store[i] == v) return i;
        return -1;
    endfunction

    // Apply one operation to the shadow store and return the snapshot after it
    function automatic deque_result_t deque_predict(
        logic [dird_pkg::ACTION_W-1:0] action,
        logic [dird_pkg::VALUE_W-1:0]  value);
        deque_result_t r;
        int            pos;
        r.status = dird_pkg::ST_DONE;
        case (action)
            dird_pkg::ACT_PUSH: begin
                if (find_entry(value) >= 0) r.status = dird_pkg::ST_DUP;  // dup checked first
                else if (shadow_store.size() >= DEPTH) r.status = dird_pkg::ST_FULL;
                else shadow_store.push_back(value);
            end
            dird_pkg::ACT_POP_TOP: begin
                if (shadow_store.size() == 0) r.status = dird_pkg::ST_NONE;
                else void'(shadow_store.pop_back());
            end
            dird_pkg::ACT_POP_BOTTOM: begin
                if (shadow_store.size() == 0) r.status = dird_pkg::ST_NONE;
                else void'(shadow_store.pop_front());
            end
            dird_pkg::ACT_REMOVE: begin
                pos = find_entry(value);
                if (pos < 0) r.status = dird_pkg::ST_NONE;
                else shadow_store.delete(pos);
            end
            default: begin  // peek and unused codes
                if (shadow_store.size() == 0) r.status = dird_pkg::ST_NONE;
            end
        endcase
        if (shadow_store.size() == 0) begin
            r.top_value    = '0;
            r.bottom_value = '0;
            r.is_empty     = 1'b1;
        end else begin
            r.top_value    = shadow_store[shadow_store.size()-1];
            r.bottom_value = shadow_store[0];
            r.is_empty     = 1'b0;
        end
        r.entry_count = dird_pkg::COUNT_OUT_W'(shadow_store.size());
        return r;
    endfunction

    task automatic compare_result(deque_result_t want, deque_result_t got, string src);
        if (got.status !== want.status) begin
            $error("%s status: expected %0d, got %0d", src, want.status, got.status);
            fail_cnt++;
        end
        if (got.top_value !== want.top_value) begin
            $error("%s top_value: expected %h, got %h", src, want.top_value, got.top_value);
            fail_cnt++;
        end
        if (got.bottom_value !== want.bottom_value) begin
            $error("%s bottom_value: expected %h, got %h", src,
                   want.bottom_value, got.bottom_value);
            fail_cnt++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("%s entry_count: expected %0d, got %0d", src,
                   want.entry_count, got.entry_count);
            fail_cnt++;
        end
        if (got.is_empty !== want.is_empty) begin
            $error("%s is_empty: expected %0d, got %0d", src, want.is_empty, got.is_empty);
            fail_cnt++;
        end
    endtask

    // Drive one input transaction; the shadow store is updated on acceptance.
    // s_tvalid gets exactly one NBA per edge: either the gap's 0 or the item's 1.
    task automatic send_op(logic [dird_pkg::ACTION_W-1:0] action,
                           logic [dird_pkg::VALUE_W-1:0] value,
                           logic typed, deque_result_t want);
        pending_t p;
        int       gap;
        if (!quiet_in && $urandom_range(0, 99) < 10) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(dird_pkg::S_TDATA_W-dird_pkg::ACTION_W-dird_pkg::VALUE_W){1'b0}},
                     value, action};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        p.model = deque_predict(action, value);
        p.typed = typed;
        p.want  = want;
        pending_results.push_back(p);
    endtask

    function automatic logic [dird_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 70)
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
        return $urandom;
    endfunction

    function automatic logic [dird_pkg::ACTION_W-1:0] ACT_ACTION_PEEK();
        return dird_pkg::ACTION_W'($urandom_range(dird_pkg::ACT_PEEK, ACT_CODE_MAX));
    endfunction

    // Grow phases push mostly so the store fills; shrink phases drain it
    task automatic random_item(bit grow);
        int                            pick;
        logic [dird_pkg::ACTION_W-1:0] act;
        logic [dird_pkg::VALUE_W-1:0]  val;
        pick = $urandom_range(0, 99);
        val  = pick_value();
        if (pick < (grow ? 65 : 20)) act = dird_pkg::ACT_PUSH;
        else if (pick < (grow ? 75 : 45)) act = dird_pkg::ACT_POP_TOP;
        else if (pick < (grow ? 85 : 70)) act = dird_pkg::ACT_POP_BOTTOM;
        else if (pick < 95) begin
            act = dird_pkg::ACT_REMOVE;
            // most removes hit a stored value, anywhere in the order
            if (shadow_store.size() != 0 && $urandom_range(0, 99) < 65)
                val = shadow_store[$urandom_range(0, shadow_store.size()-1)];
        end else
            act = ACT_ACTION_PEEK();
        send_op(act, val, 1'b0, NO_WANT);
    endtask

    // Result side: check each accepted transaction, then pick next m_tready
    always @(posedge aclk) begin
        deque_result_t got;
        pending_t      p;
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = m_tdata[1:0];
            got.top_value    = m_tdata[33:2];
            got.bottom_value = m_tdata[65:34];
            got.entry_count  = m_tdata[70:66];
            got.is_empty     = m_tdata[71];
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                fail_cnt++;
            end else begin
                p = pending_results.pop_front();
                compare_result(p.model, got, "model");
                if (p.typed) compare_result(p.want, got, "table");
            end
        end
        if (quiet_out) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        stim_row_t row;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        value_pool[0] = 32'h7fffffff;
        value_pool[1] = 32'h80000000;
        value_pool[2] = 32'h0;
        value_pool[3] = 32'hffffffff;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < 25; i++) begin
            row = DIR_ROWS[i];
            for (int r = 0; r < row.reps; r++)
                send_op(row.action, row.value + r, row.typed, row.want);
        end

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet_in  = 1'b1;
                quiet_out = 1'b1;
            end
            // hold off once until the block has drained completely
            if (i == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            random_item(((i / 100) % 2) == 0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);   // catch any stray extra result
        if (fail_cnt == 0) begin
            $display("** dedup_input_restricted_deque_core: PASSED **");
        end else begin
            $display("** dedup_input_restricted_deque_core: FAILED **");
        end
        $finish;
    end

endmodule
